/* rtl/wtsw_pkg.sv */
// ----------------------------------------------------------------------------
// wtsw_pkg: shared types and constants
// Field widths, command codes, register indexes and the control and status
// structs between the sequencer and the datapath of the weekly time switch.
// ----------------------------------------------------------------------------
package wtsw_pkg;

	localparam int MODE_W   = 4;
	localparam int BYTE_W   = 8;
	localparam int DAY_W    = 4;
	localparam int MIN_W    = 12;
	localparam int CNT_W    = 4;
	localparam int HOUR_W   = 7;
	localparam int MIH_W    = 6;
	localparam int MARK_N   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 12;

	// command codes
	localparam logic [MODE_W-1:0] MODE_TICK        = 4'd0;
	localparam logic [MODE_W-1:0] MODE_RESET_BYTE  = 4'd1;
	localparam logic [MODE_W-1:0] MODE_SET_BYTE    = 4'd2;
	localparam logic [MODE_W-1:0] MODE_RESET_BIT   = 4'd3;
	localparam logic [MODE_W-1:0] MODE_SET_BIT     = 4'd4;
	localparam logic [MODE_W-1:0] MODE_READ_BIT    = 4'd5;
	localparam logic [MODE_W-1:0] MODE_READ_BYTE   = 4'd6;
	localparam logic [MODE_W-1:0] MODE_SET_TIME    = 4'd7;
	localparam logic [MODE_W-1:0] MODE_WRITE_ENTRY = 4'd8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_MINUTE  = 2'd2;

	localparam logic [CNT_W-1:0] RST_OUTPUT_COUNT = 4'd8;
	localparam logic [CNT_W-1:0] RST_INPUT_COUNT  = 4'd8;
	localparam logic [MIN_W-1:0] RST_LAST_MINUTE  = 12'd1439;

	localparam logic [CNT_W-1:0] PIN_MAX     = 4'd8;
	localparam logic [8:0]       SEC_LAST    = 9'd59;
	localparam logic [DAY_W-1:0] DAY_LAST    = 4'd6;
	localparam logic [DAY_W-1:0] DAY_EVERY   = 4'd7;
	localparam logic [23:0]      DIV60_RECIP = 24'd2185;  // ceil(2^17 / 60), exact to 4095
	localparam logic [12:0]      MIN_PER_HR  = 13'd60;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BYTE_W-1:0] value;
		logic [DAY_W-1:0]  day;
		logic [MIN_W-1:0]  minute_of_day;
		logic [BYTE_W-1:0] second;
		logic [BYTE_W-1:0] entry_index;
		logic [BYTE_W-1:0] reset_mask;
		logic [BYTE_W-1:0] set_mask;
		logic [BYTE_W-1:0] input_pins;
	} item_t;

	typedef struct packed {
		logic              status;
		logic [BYTE_W-1:0] read_value;
		logic [BYTE_W-1:0] output_bits;
		logic [HOUR_W-1:0] hour;
		logic [MIH_W-1:0]  minute_in_hour;
	} result_t;

	typedef struct packed {
		logic ld_item;   // capture the accepted command
		logic exec;      // execute the captured command
		logic scan_rd;   // read one schedule entry
		logic div_mul;   // first step of minute / 60
		logic out_load;  // load the result register
	} dp_cmd_t;

	typedef struct packed {
		logic fresh;     // executing tick rolls into a new minute
	} dp_stat_t;

endpackage

/* rtl/wtsw_if.sv */
// ----------------------------------------------------------------------------
// wtsw_if: channel interfaces
// Command, result and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface wtsw_cmd_if import wtsw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [BYTE_W-1:0] value;
	logic [DAY_W-1:0]  day;
	logic [MIN_W-1:0]  minute_of_day;
	logic [BYTE_W-1:0] second;
	logic [BYTE_W-1:0] entry_index;
	logic [BYTE_W-1:0] reset_mask;
	logic [BYTE_W-1:0] set_mask;
	logic [BYTE_W-1:0] input_pins;

	modport source (
		output valid, mode, value, day, minute_of_day, second, entry_index,
		       reset_mask, set_mask, input_pins,
		input  ready
	);
	modport sink (
		input  valid, mode, value, day, minute_of_day, second, entry_index,
		       reset_mask, set_mask, input_pins,
		output ready
	);
endinterface

interface wtsw_rsp_if import wtsw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              status;
	logic [BYTE_W-1:0] read_value;
	logic [BYTE_W-1:0] output_bits;
	logic [HOUR_W-1:0] hour;
	logic [MIH_W-1:0]  minute_in_hour;

	modport source (
		output valid, status, read_value, output_bits, hour, minute_in_hour,
		input  ready
	);
	modport sink (
		input  valid, status, read_value, output_bits, hour, minute_in_hour,
		output ready
	);
endinterface

interface wtsw_cfg_if import wtsw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/wtsw_ctrl.sv */
// ----------------------------------------------------------------------------
// wtsw_ctrl: command sequencer
// Accepts a command, steps it through execute, schedule scan and the
// hour/minute split, and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module wtsw_ctrl import wtsw_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int AW      = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  dp_stat_t      stat,
	output dp_cmd_t       cmd,
	output logic [AW-1:0] scan_addr
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_DIV1 = 3'd3;
	localparam logic [2:0] ST_DIV2 = 3'd4;

	localparam logic [AW-1:0] SCAN_LAST = AW'(ENTRIES - 1);

	logic [2:0]    state_q;
	logic [AW-1:0] cnt_q;
	logic          out_vld_q;
	logic          out_free;

	assign out_free  = !out_vld_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_vld_q;
	assign scan_addr = cnt_q;

	always_comb begin
		cmd          = '0;
		cmd.ld_item  = (state_q == ST_IDLE) && in_valid;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.scan_rd  = (state_q == ST_SCAN);
		cmd.div_mul  = (state_q == ST_DIV1);
		cmd.out_load = (state_q == ST_DIV2) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					cnt_q   <= '0;
					state_q <= stat.fresh ? ST_SCAN : ST_DIV1;
				end
				ST_SCAN: begin
					if (cnt_q == SCAN_LAST)
						state_q <= ST_DIV1;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_DIV1: begin
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/wtsw_dp.sv */
// ----------------------------------------------------------------------------
// wtsw_dp: time switch datapath
// Configuration, clock, output and marker registers, the schedule memory
// with per-entry valid bits, and the minute-of-day to hour/minute split.
// ----------------------------------------------------------------------------
module wtsw_dp import wtsw_pkg::*; #(
	parameter int OUTPUT_WIDTH = 8,
	parameter int ENTRIES      = 16,
	parameter int AW           = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  logic [AW-1:0]        scan_addr,
	input  item_t                item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output result_t              res
);

	localparam logic [CNT_W-1:0] OW_CNT = CNT_W'(OUTPUT_WIDTH);
	localparam logic [8:0]       ENT_N  = 9'(ENTRIES);

	// configuration
	logic [CNT_W-1:0] ocnt_q;
	logic [CNT_W-1:0] icnt_q;
	logic [MIN_W-1:0] last_q;

	// architectural state
	logic [OUTPUT_WIDTH-1:0] out_q;
	logic [MARK_N-1:0]       mrk_q;
	logic [DAY_W-1:0]        day_q;
	logic [MIN_W-1:0]        min_q;
	logic [BYTE_W-1:0]       sec_q;

	item_t             item_q;
	logic              st_q;
	logic [BYTE_W-1:0] rd_q;
	logic [HOUR_W-1:0] hour_q;
	result_t           res_q;

	// schedule memory: day[31:28] minute[27:16] reset[15:8] set[7:0]
	logic [31:0]        mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	logic [31:0]        ent_s1;
	logic               hit_s1;

	// limits and masks
	logic [CNT_W-1:0]        olim;
	logic [CNT_W-1:0]        ilim;
	logic [BYTE_W-1:0]       omask8;
	logic [BYTE_W-1:0]       imask8;
	logic [OUTPUT_WIDTH-1:0] omask;
	logic                    marker;
	logic [MARK_N-1:0]       mbit;
	logic [OUTPUT_WIDTH-1:0] obit;
	logic                    obad;
	logic                    ibad;
	logic                    idx_ok;

	// tick arithmetic
	logic [8:0]       sec_inc;
	logic             fresh;
	logic [MIN_W:0]   min_inc;
	logic             day_wrap;
	logic [DAY_W-1:0] day_inc;

	// exec results
	logic [OUTPUT_WIDTH-1:0] out_n;
	logic [MARK_N-1:0]       mrk_n;
	logic [DAY_W-1:0]        day_n;
	logic [MIN_W-1:0]        min_n;
	logic [BYTE_W-1:0]       sec_n;
	logic                    st_n;
	logic [BYTE_W-1:0]       rd_n;
	logic                    we;

	// scan apply
	logic [DAY_W-1:0]        e_day;
	logic [MIN_W-1:0]        e_min;
	logic                    e_match;
	logic [OUTPUT_WIDTH-1:0] e_clr;
	logic [OUTPUT_WIDTH-1:0] e_set;

	// minute / 60
	logic [23:0]      prod;
	logic [12:0]      qx60;
	logic [MIN_W-1:0] rem;

	assign olim   = (ocnt_q > OW_CNT) ? OW_CNT : ocnt_q;
	assign ilim   = (icnt_q > PIN_MAX) ? PIN_MAX : icnt_q;
	assign omask8 = BYTE_W'((9'd1 << olim) - 9'd1);
	assign imask8 = BYTE_W'((9'd1 << ilim) - 9'd1);
	assign omask  = omask8[OUTPUT_WIDTH-1:0];

	assign marker = item_q.value[7];
	assign mbit   = MARK_N'(1) << item_q.value[3:0];
	assign obit   = OUTPUT_WIDTH'(8'd1 << item_q.value[2:0]);
	assign obad   = {4'd0, item_q.value} >= {8'd0, olim};
	assign ibad   = {4'd0, item_q.value} >= {8'd0, ilim};
	assign idx_ok = {1'b0, item_q.entry_index} < ENT_N;

	// tick: seconds, then minute overflow past last_minute, then day range
	assign sec_inc  = {1'b0, sec_q} + 9'd1;
	assign fresh    = sec_inc > SEC_LAST;
	assign min_inc  = {1'b0, min_q} + {{MIN_W{1'b0}}, fresh};
	assign day_wrap = min_inc > {1'b0, last_q};
	assign day_inc  = day_wrap ? (day_q + 1'b1) : day_q;

	assign stat.fresh = (item_q.mode == MODE_TICK) && fresh;

	always_comb begin
		out_n = out_q;
		mrk_n = mrk_q;
		day_n = day_q;
		min_n = min_q;
		sec_n = sec_q;
		st_n  = 1'b0;
		rd_n  = '0;
		we    = 1'b0;
		case (item_q.mode)
			MODE_TICK: begin
				sec_n = fresh ? '0 : sec_inc[BYTE_W-1:0];
				min_n = day_wrap ? '0 : min_inc[MIN_W-1:0];
				day_n = (day_inc > DAY_LAST) ? '0 : day_inc;
			end
			MODE_RESET_BYTE: begin
				out_n = out_q & ~(item_q.value[OUTPUT_WIDTH-1:0] & omask);
			end
			MODE_SET_BYTE: begin
				out_n = out_q | (item_q.value[OUTPUT_WIDTH-1:0] & omask);
			end
			MODE_RESET_BIT, MODE_SET_BIT: begin
				if (marker) begin
					mrk_n = (item_q.mode == MODE_SET_BIT) ? (mrk_q | mbit) : (mrk_q & ~mbit);
				end else if (obad) begin
					st_n = 1'b1;
				end else begin
					out_n = (item_q.mode == MODE_SET_BIT) ? (out_q | obit) : (out_q & ~obit);
				end
			end
			MODE_READ_BIT: begin
				if (marker)
					rd_n = BYTE_W'(mrk_q[item_q.value[3:0]]);
				else if (ibad)
					st_n = 1'b1;
				else
					rd_n = BYTE_W'(item_q.input_pins[item_q.value[2:0]]);
			end
			MODE_READ_BYTE: begin
				rd_n = item_q.input_pins & imask8;
			end
			MODE_SET_TIME: begin
				day_n = item_q.day;
				min_n = item_q.minute_of_day;
				sec_n = item_q.second;
			end
			MODE_WRITE_ENTRY: begin
				if (idx_ok)
					we = 1'b1;
				else
					st_n = 1'b1;
			end
			default: begin
				st_n = 1'b1;
			end
		endcase
	end

	// entry read in the previous cycle; match against the updated clock
	assign e_day   = ent_s1[31:28];
	assign e_min   = ent_s1[27:16];
	assign e_match = hit_s1 && ((e_day == DAY_EVERY) || (e_day == day_q)) && (e_min == min_q);
	assign e_clr   = ent_s1[OUTPUT_WIDTH+7:8] & omask;
	assign e_set   = ent_s1[OUTPUT_WIDTH-1:0] & omask;

	assign prod = 24'(min_q) * DIV60_RECIP;
	assign qx60 = 13'(hour_q) * MIN_PER_HR;
	assign rem  = min_q - qx60[MIN_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.exec && we)
			mem[item_q.entry_index[AW-1:0]] <= {item_q.day, item_q.minute_of_day,
			                                    item_q.reset_mask, item_q.set_mask};
		ent_s1 <= mem[scan_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_item)
			item_q <= item;
		if (cmd.exec) begin
			st_q <= st_n;
			rd_q <= rd_n;
		end
		if (cmd.div_mul)
			hour_q <= prod[23:17];
		if (cmd.out_load) begin
			res_q.status         <= st_q;
			res_q.read_value     <= rd_q;
			res_q.output_bits    <= BYTE_W'(out_q);
			res_q.hour           <= hour_q;
			res_q.minute_in_hour <= rem[MIH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= RST_OUTPUT_COUNT;
			icnt_q <= RST_INPUT_COUNT;
			last_q <= RST_LAST_MINUTE;
			out_q  <= '0;
			mrk_q  <= '0;
			day_q  <= '0;
			min_q  <= '0;
			sec_q  <= '0;
			vld_q  <= '0;
			hit_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OUTPUT_COUNT: ocnt_q <= cfg_data[CNT_W-1:0];
					CFG_INPUT_COUNT:  icnt_q <= cfg_data[CNT_W-1:0];
					CFG_LAST_MINUTE:  last_q <= cfg_data;
					default: ;
				endcase
			end
			hit_s1 <= cmd.scan_rd && vld_q[scan_addr];
			if (cmd.exec) begin
				out_q <= out_n;
				mrk_q <= mrk_n;
				day_q <= day_n;
				min_q <= min_n;
				sec_q <= sec_n;
				if (we)
					vld_q[item_q.entry_index[AW-1:0]] <= 1'b1;
			end else if (e_match) begin
				out_q <= (out_q & ~e_clr) | e_set;
			end
		end
	end

	assign res = res_q;

endmodule

/* rtl/weekly_time_switch_io_controller.sv */
// Sequence: a command beat steps through execute, then, on a tick that starts a
// new minute, the schedule scan (one entry per cycle through the single read
// port of the schedule memory), then DIV1 and DIV2; DIV2 holds the result
// register load while an earlier result still waits to be taken. The next
// command is taken while a result waits in the output register.
// Reset: asynchronous; clears clock, outputs, markers and all entry valid bits.
// ----------------------------------------------------------------------------
// weekly_time_switch_io_controller: weekly programmable time switch
// Command-driven output/marker/input access with a seconds/minute/day clock
// and a scanned schedule table that fires on each new minute.
// ----------------------------------------------------------------------------
module weekly_time_switch_io_controller import wtsw_pkg::*; #(
	parameter int OUTPUT_WIDTH = 8,
	parameter int ENTRIES      = 16
) (
	input  logic clk,
	input  logic arst_n,
	wtsw_cmd_if.sink   cmd,
	wtsw_rsp_if.source rsp,
	wtsw_cfg_if.sink   cfg
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	dp_cmd_t       dp_cmd;
	dp_stat_t      dp_stat;
	logic [AW-1:0] scan_addr;
	item_t         item;
	result_t       res;

	assign item.mode          = cmd.mode;
	assign item.value         = cmd.value;
	assign item.day           = cmd.day;
	assign item.minute_of_day = cmd.minute_of_day;
	assign item.second        = cmd.second;
	assign item.entry_index   = cmd.entry_index;
	assign item.reset_mask    = cmd.reset_mask;
	assign item.set_mask      = cmd.set_mask;
	assign item.input_pins    = cmd.input_pins;

	assign cfg.ready = 1'b1;

	wtsw_ctrl #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd),
		.scan_addr (scan_addr)
	);

	wtsw_dp #(
		.OUTPUT_WIDTH (OUTPUT_WIDTH),
		.ENTRIES      (ENTRIES),
		.AW           (AW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.scan_addr (scan_addr),
		.item      (item),
		.cfg_we    (cfg.valid && cfg.ready),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.res       (res)
	);

	assign rsp.status         = res.status;
	assign rsp.read_value     = res.read_value;
	assign rsp.output_bits    = res.output_bits;
	assign rsp.hour           = res.hour;
	assign rsp.minute_in_hour = res.minute_in_hour;

`ifndef SYNTHESIS
	// one command in flight: no second beat right behind the first
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command accepted twice in a row");

	a_err_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> rsp.read_value == 8'd0)
		else $error("error result carries read data");

	a_min_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.minute_in_hour < 6'd60)
		else $error("minute in hour out of range");
`endif

endmodule
